FILE: hdl/dlvp_pkg.sv
package dlvp_pkg;

   localparam int VEL_W      = 16;
   localparam int PV_W       = 17;
   localparam int DEC_W      = 16;
   localparam int DIST_W     = 24;
   localparam int MUL_W      = 24;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ROOT_IN_W  = 50;
   localparam int ROOT_W     = ROOT_IN_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int STEP_CNT_W = $clog2(ROOT_STEPS);

   localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
   localparam logic [DEC_W-1:0]  DEC_RESET = 16'd1000;

   typedef struct packed {
      logic                   new_velocity_sign;
      logic [PV_W-2:0]        new_velocity_mag;
      logic                   reached_target;
      logic                   last_out;
   } res_type;

   typedef struct packed {
      logic                 start;
      logic [ROOT_IN_W-1:0] radicand;
   } root_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } root_rsp_type;

endpackage

FILE: hdl/dlvp_req_if.sv
interface dlvp_req_if import dlvp_pkg::*; #(
   parameter int POS_WIDTH = 32
) ();
   logic                        valid;
   logic                        ready;
   logic                        first;
   logic [VEL_W-1:0]            start_velocity;
   logic [VEL_W-1:0]            target_velocity;
   logic signed [POS_WIDTH-1:0] pos_x;
   logic signed [POS_WIDTH-1:0] pos_y;
   logic signed [PV_W-1:0]      point_velocity;
   logic                        last;

   modport source (
      output valid, first, start_velocity, target_velocity, pos_x, pos_y,
             point_velocity, last,
      input  ready
   );

   modport sink (
      input  valid, first, start_velocity, target_velocity, pos_x, pos_y,
             point_velocity, last,
      output ready
   );
endinterface

FILE: hdl/dlvp_rsp_if.sv
interface dlvp_rsp_if import dlvp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [PV_W-1:0] new_velocity;
   logic                   reached_target;
   logic                   last_out;

   modport source (
      output valid, new_velocity, reached_target, last_out,
      input  ready
   );

   modport sink (
      input  valid, new_velocity, reached_target, last_out,
      output ready
   );
endinterface

FILE: hdl/decel_limited_velocity_profile_unit.sv
// constant-deceleration velocity limiter for trajectory points
//
// req_ch carries one trajectory point per beat. a point with first set loads
// the start (limit) and target (floor) velocities; every later point lowers
// the limit to max(floor, isqrt(limit^2 - 2*decel*dist)) where dist is the
// planar step from the previous point, saturated at 2^24-1 mm.
// rsp_ch returns one beat per point: the point velocity capped at the limit
// (unchanged on a last point), a flag on the first point reaching the floor,
// and a copy of last.
// csr_wr_en/csr_wr_data write the deceleration limit; write only while idle.
// a first point goes from acceptance straight to the done state and on into the
// output register; a later point runs abs-diff, multiply and compare steps
// and at most two 25-step passes of the shared square-root unit (the first
// root is skipped when the step distance saturates).
// req_ch.ready is high only between points, so one point is in work at a time;
// the result sits in an output register, so the next point is taken while a
// stalled rsp_ch beat waits; the finished point holds until that slot frees.
// reset clears limit, floor, previous position and the end marker to zero
// and sets the deceleration register to 1000 mm/s^2.
module decel_limited_velocity_profile_unit import dlvp_pkg::*; #(
   parameter int POS_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [DEC_W-1:0]  csr_wr_data,
   dlvp_req_if.sink          req_ch,
   dlvp_rsp_if.source        rsp_ch
);

   // configuration register
   logic [DEC_W-1:0] max_decel_ff;

   // output slot
   logic                   rsp_valid_ff;
   logic signed [PV_W-1:0] rsp_vel_ff;
   logic                   rsp_reached_ff;
   logic                   rsp_last_ff;

   logic    out_free;
   logic    res_valid;
   res_type res;

   // slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   dlvp_core #(
      .POS_WIDTH (POS_WIDTH)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (req_ch.valid),
      .in_ready           (req_ch.ready),
      .in_first           (req_ch.first),
      .in_start_velocity  (req_ch.start_velocity),
      .in_target_velocity (req_ch.target_velocity),
      .in_pos_x           (req_ch.pos_x),
      .in_pos_y           (req_ch.pos_y),
      .in_point_velocity  (req_ch.point_velocity),
      .in_last            (req_ch.last),
      .max_decel          (max_decel_ff),
      .out_free           (out_free),
      .res_valid          (res_valid),
      .res                (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_decel_ff <= DEC_RESET;
      end else if (csr_wr_en) begin
         max_decel_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid) begin
         rsp_vel_ff     <= {res.new_velocity_sign, res.new_velocity_mag};
         rsp_reached_ff <= res.reached_target;
         rsp_last_ff    <= res.last_out;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.new_velocity   = rsp_vel_ff;
   assign rsp_ch.reached_target = rsp_reached_ff;
   assign rsp_ch.last_out       = rsp_last_ff;

   // a finished point must never overwrite a beat still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !res_valid)
      else $error("result dropped on stalled output");

   // a stalled beat stays offered
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> rsp_ch.valid)
      else $error("stalled beat withdrawn");

   // and its payload does not move
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=>
         $stable({rsp_ch.new_velocity, rsp_ch.reached_target, rsp_ch.last_out}))
      else $error("stalled beat payload changed");

endmodule

FILE: hdl/dlvp_root.sv
// digit-by-digit integer square root, two radicand bits per cycle
module dlvp_root import dlvp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  root_req_type req,
   output root_rsp_type rsp
);

   logic [ROOT_IN_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic             fits;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[ROOT_IN_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rad_in  = req.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[ROOT_IN_W-3:0], 2'b00};
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == STEP_CNT_W'(ROOT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("root start while busy");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !busy_in) |=> done_ff)
      else $error("root run ended without done");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("root done held longer than one cycle");

endmodule

FILE: hdl/dlvp_core.sv
// sequencer and shared datapath: abs-diff, 24x24 multiplier, root unit
module dlvp_core import dlvp_pkg::*; #(
   parameter int POS_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        in_first,
   input  logic [VEL_W-1:0]            in_start_velocity,
   input  logic [VEL_W-1:0]            in_target_velocity,
   input  logic signed [POS_WIDTH-1:0] in_pos_x,
   input  logic signed [POS_WIDTH-1:0] in_pos_y,
   input  logic signed [PV_W-1:0]      in_point_velocity,
   input  logic                        in_last,
   input  logic [DEC_W-1:0]            max_decel,
   input  logic                        out_free,
   output logic                        res_valid,
   output res_type                     res
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DX    = 4'd1;
   localparam logic [3:0] S_DY    = 4'd2;
   localparam logic [3:0] S_SQY   = 4'd3;
   localparam logic [3:0] S_ADD   = 4'd4;
   localparam logic [3:0] S_ROOT1 = 4'd5;
   localparam logic [3:0] S_DEC   = 4'd6;
   localparam logic [3:0] S_VSQ   = 4'd7;
   localparam logic [3:0] S_CMP   = 4'd8;
   localparam logic [3:0] S_ROOT2 = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   localparam int DIFF_W = POS_WIDTH + 1;
   localparam int MAG_W  = (DIFF_W > DIST_W + 1) ? DIFF_W : DIST_W + 1;

   logic [3:0] state_ff, state_in;

   // latched beat
   logic                        first_ff, last_ff;
   logic [VEL_W-1:0]            start_ff, target_ff;
   logic signed [POS_WIDTH-1:0] x_ff, y_ff;
   logic signed [PV_W-1:0]      pv_ff;

   // profile state
   logic [VEL_W-1:0]            limit_ff, limit_in;
   logic [VEL_W-1:0]            floor_ff, floor_in;
   logic signed [POS_WIDTH-1:0] prev_x_ff, prev_x_in;
   logic signed [POS_WIDTH-1:0] prev_y_ff, prev_y_in;
   logic                        end_found_ff, end_found_in;

   // working registers
   logic [DIST_W-1:0]    d_ff, d_in;
   logic                 sat_ff, sat_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [ROOT_IN_W-2:0] acc_ff, acc_in;
   logic [VEL_W-1:0]     nl_ff, nl_in;

   root_req_type root_req;
   root_rsp_type root_rsp;

   // shared abs-diff unit
   logic signed [POS_WIDTH-1:0] ad_a, ad_b;
   logic signed [DIFF_W-1:0]    ad_diff;
   logic [DIFF_W-1:0]           ad_mag;
   logic [MAG_W-1:0]            ad_ext;
   logic                        ad_over;

   // shared multiplier
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;

   logic [ROOT_IN_W-1:0] sum_sq, v_diff;
   logic [VEL_W-1:0]     lim_new;
   logic signed [PV_W-1:0] lim_s;
   logic                 reach_new;

   dlvp_root u_root (
      .clock (clock),
      .reset (reset),
      .req   (root_req),
      .rsp   (root_rsp)
   );

   assign ad_a    = (state_ff == S_DY) ? y_ff : x_ff;
   assign ad_b    = (state_ff == S_DY) ? prev_y_ff : prev_x_ff;
   assign ad_diff = DIFF_W'(ad_a) - DIFF_W'(ad_b);
   assign ad_mag  = ad_diff[DIFF_W-1] ? DIFF_W'(-ad_diff) : DIFF_W'(ad_diff);
   assign ad_ext  = MAG_W'(ad_mag);
   assign ad_over = ad_ext > MAG_W'(DIST_MAX);

   always_comb begin
      mul_a = d_ff;
      mul_b = d_ff;
      unique case (state_ff)
         S_DEC: begin
            mul_a = MUL_W'(max_decel);
         end
         S_VSQ: begin
            mul_a = MUL_W'(limit_ff);
            mul_b = MUL_W'(limit_ff);
         end
         default: begin
            mul_a = d_ff;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign sum_sq = {1'b0, acc_ff} + ROOT_IN_W'(prod_ff);
   assign v_diff = ROOT_IN_W'(prod_ff) - {1'b0, acc_ff};

   // limit and reached flag for the beat being finished
   always_comb begin
      if (first_ff) begin
         lim_new   = start_ff;
         reach_new = 1'b0;
      end else begin
         lim_new   = (nl_ff < floor_ff) ? floor_ff : nl_ff;
         reach_new = !end_found_ff && (lim_new <= floor_ff);
      end
   end

   assign lim_s = signed'({1'b0, lim_new});

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      floor_in     = floor_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      end_found_in = end_found_ff;
      d_in         = d_ff;
      sat_in       = sat_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      nl_in        = nl_ff;
      root_req     = '{start: 1'b0, radicand: sum_sq};
      res_valid    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               state_in = in_first ? S_DONE : S_DX;
            end
         end
         S_DX: begin
            d_in     = ad_ext[DIST_W-1:0];
            sat_in   = ad_over;
            state_in = S_DY;
         end
         S_DY: begin
            prod_in  = mul_p;
            d_in     = ad_ext[DIST_W-1:0];
            sat_in   = sat_ff | ad_over;
            state_in = S_SQY;
         end
         S_SQY: begin
            acc_in   = (ROOT_IN_W-1)'(prod_ff);
            prod_in  = mul_p;
            state_in = S_ADD;
         end
         S_ADD: begin
            if (sat_ff) begin
               d_in     = DIST_MAX;
               state_in = S_DEC;
            end else begin
               root_req = '{start: 1'b1, radicand: sum_sq};
               state_in = S_ROOT1;
            end
         end
         S_ROOT1: begin
            if (root_rsp.done) begin
               d_in     = root_rsp.root[ROOT_W-1] ? DIST_MAX : root_rsp.root[DIST_W-1:0];
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            prod_in  = mul_p;
            state_in = S_VSQ;
         end
         S_VSQ: begin
            acc_in   = {prod_ff, 1'b0};
            prod_in  = mul_p;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (v_diff[ROOT_IN_W-1]) begin
               nl_in    = '0;
               state_in = S_DONE;
            end else begin
               root_req = '{start: 1'b1, radicand: v_diff};
               state_in = S_ROOT2;
            end
         end
         S_ROOT2: begin
            if (root_rsp.done) begin
               nl_in    = root_rsp.root[VEL_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               res_valid    = 1'b1;
               limit_in     = lim_new;
               floor_in     = first_ff ? target_ff : floor_ff;
               end_found_in = first_ff ? 1'b0 : (end_found_ff | reach_new);
               prev_x_in    = x_ff;
               prev_y_in    = y_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      logic signed [PV_W-1:0] nv;
      nv = (!last_ff && (lim_s < pv_ff)) ? lim_s : pv_ff;
      res.new_velocity_sign = nv[PV_W-1];
      res.new_velocity_mag  = nv[PV_W-2:0];
      res.reached_target    = reach_new;
      res.last_out          = last_ff;
   end

   assign in_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= '0;
         floor_ff     <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         end_found_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         floor_ff     <= floor_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         end_found_ff <= end_found_in;
      end
      if (in_valid && in_ready) begin
         first_ff  <= in_first;
         last_ff   <= in_last;
         start_ff  <= in_start_velocity;
         target_ff <= in_target_velocity;
         x_ff      <= in_pos_x;
         y_ff      <= in_pos_y;
         pv_ff     <= in_point_velocity;
      end
      d_ff    <= d_in;
      sat_ff  <= sat_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      nl_ff   <= nl_in;
   end

   a_first_goes_done: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && in_first) |=> (state_ff == S_DONE))
      else $error("first beat did not go straight to done");

   a_limit_above_floor: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !first_ff) |=> (limit_ff >= floor_ff))
      else $error("limit fell below floor");

   a_flag_sets_end: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.reached_target) |=> end_found_ff)
      else $error("reached flag without end marker");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import dlvp_pkg::*;

   localparam int POS_W     = 32;
   localparam int LIMIT_CYC = 1000000;
   localparam int HOLD_CYC  = 400;
   localparam int PHASE_PTS = 220;
   localparam int DRAIN_CYC = 100;

   // receiver stall patterns
   typedef enum int {
      RDY_ALWAYS,
      RDY_HALF,
      RDY_SPARSE
   } stall_mode_type;

   // one trajectory point as it goes out on req_ch
   typedef struct {
      bit                    first;
      bit [VEL_W-1:0]        start_v;
      bit [VEL_W-1:0]        target_v;
      bit signed [POS_W-1:0] pos_x;
      bit signed [POS_W-1:0] pos_y;
      bit signed [PV_W-1:0]  pv;
      bit                    last;
   } point_type;

   // what rsp_ch should return for one point
   typedef struct {
      bit signed [PV_W-1:0] vel;
      bit                   reached;
      bit                   last;
   } capped_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [DEC_W-1:0] csr_wr_data;

   dlvp_req_if #(.POS_WIDTH(POS_W)) req_ch ();
   dlvp_rsp_if                      rsp_ch ();

   decel_limited_velocity_profile_unit #(.POS_WIDTH(POS_W)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // points waiting for the driver, expected beats waiting for the monitor
   point_type  point_q[$];
   capped_type capped_q[$];

   // shadow of the block state, reset values
   bit [DEC_W-1:0]        decel_cfg = DEC_RESET;
   bit [VEL_W-1:0]        lim_vel   = '0;
   bit [VEL_W-1:0]        floor_vel = '0;
   bit signed [POS_W-1:0] prev_x    = '0;
   bit signed [POS_W-1:0] prev_y    = '0;
   bit                    end_found = 1'b0;

   // bookkeeping, counters only move at the rising edge except queued_cnt and the end-of-run err_cnt check
   int cycle_cnt    = 0;
   int queued_cnt   = 0;
   int accepted_cnt = 0;
   int rsp_beats    = 0;
   int err_cnt      = 0;
   bit req_took     = 1'b0;

   // driver burst state
   int burst_left = 0;
   int gap_left   = 0;

   // receiver stall state
   stall_mode_type seg_mode     = RDY_ALWAYS;
   int             seg_left     = 0;
   int             hold_left    = 0;
   int             holds_done   = 0;
   int             next_hold_at = 150;

   point_type  got_pt;
   capped_type want_res;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor of the square root, one result bit at a time from the top
   function automatic bit [63:0] int_sqrt(bit [63:0] val);
      bit [63:0] root;
      bit [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= val) root = trial;
      end
      return root;
   endfunction

   // advance the shadow limit by one point and return the beat it causes
   function automatic capped_type decel_limit_step(point_type p);
      capped_type r;
      longint     dxs;
      longint     dys;
      bit [63:0]  dx;
      bit [63:0]  dy;
      bit [63:0]  step_dist;
      bit [63:0]  v_sq;
      bit [63:0]  shed;
      bit [63:0]  nl;
      int         lim_i;
      int         pv_i;
      r.vel     = p.pv;
      r.reached = 1'b0;
      r.last    = p.last;
      if (p.first) begin
         // new profile: load limit and floor, re-arm the target flag
         lim_vel   = p.start_v;
         floor_vel = p.target_v;
         end_found = 1'b0;
      end else begin
         dxs = longint'(p.pos_x) - longint'(prev_x);
         dys = longint'(p.pos_y) - longint'(prev_y);
         dx  = (dxs < 0) ? 64'(-dxs) : 64'(dxs);
         dy  = (dys < 0) ? 64'(-dys) : 64'(dys);
         // step distance saturates at the 24-bit ceiling
         if (dx > 64'(DIST_MAX) || dy > 64'(DIST_MAX)) begin
            step_dist = 64'(DIST_MAX);
         end else begin
            step_dist = int_sqrt(dx * dx + dy * dy);
            if (step_dist > 64'(DIST_MAX)) step_dist = 64'(DIST_MAX);
         end
         // v^2 - 2*a*d, clamped at zero, then held up at the floor
         v_sq = 64'(lim_vel) * 64'(lim_vel);
         shed = 64'(decel_cfg) * step_dist * 64'd2;
         nl   = (v_sq > shed) ? int_sqrt(v_sq - shed) : 64'd0;
         if (nl < 64'(floor_vel)) nl = 64'(floor_vel);
         lim_vel = nl[VEL_W-1:0];
         if (!end_found && lim_vel <= floor_vel) begin
            end_found = 1'b1;
            r.reached = 1'b1;
         end
      end
      prev_x = p.pos_x;
      prev_y = p.pos_y;
      // cap at the limit unless this is the final point
      lim_i = int'(lim_vel);
      pv_i  = int'(p.pv);
      if (!p.last && lim_i < pv_i) r.vel = PV_W'(lim_i);
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (err_cnt < 200) $display("[%0t] mismatch: %s", $realtime, msg);
      err_cnt++;
   endtask

   function automatic point_type mk_point(bit first, int sv, int tv, int x, int y, int pv,
                                          bit last);
      point_type p;
      p.first    = first;
      p.start_v  = sv[VEL_W-1:0];
      p.target_v = tv[VEL_W-1:0];
      p.pos_x    = x;
      p.pos_y    = y;
      p.pv       = pv[PV_W-1:0];
      p.last     = last;
      return p;
   endfunction

   // point velocity: mostly positive, a share over -65535..65535
   function automatic int rand_pv();
      if ($urandom_range(0, 5) == 0) return int'($urandom_range(0, 131070)) - 65535;
      return int'($urandom_range(0, 65535));
   endfunction

   // signed step of up to 2^scale_log mm
   function automatic int rand_step(int scale_log);
      int mag;
      mag = int'($urandom_range(0, 1 << scale_log));
      return ($urandom_range(0, 1) == 1) ? -mag : mag;
   endfunction

   task automatic queue_point(point_type p);
      point_q.insert(point_q.size(), p);
      queued_cnt++;
   endtask

   // one slow-down profile: a start point, a run of steps, usually a final point
   task automatic add_profile();
      int n;
      int scale_log;
      int sv;
      int tv;
      int x;
      int y;
      bit ends;
      bit lst;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(3, 20);
      sv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                        : $urandom_range(1000, 65535);
      case ($urandom_range(0, 3))
         0: tv = 0;
         1: tv = $urandom_range(0, 65535);
         default: tv = $urandom_range(0, sv / 4);
      endcase
      if ($urandom_range(0, 1) == 0) begin
         x = $urandom;
         y = $urandom;
      end else begin
         x = int'($urandom_range(0, 20000)) - 10000;
         y = int'($urandom_range(0, 20000)) - 10000;
      end
      scale_log = $urandom_range(0, 25);
      // a share of profiles is broken off without a final point
      ends = $urandom_range(0, 7) != 0;
      queue_point(mk_point(1'b1, sv, tv, x, y, rand_pv(), ends && n == 1));
      for (int i = 1; i < n; i++) begin
         x   = x + rand_step(scale_log);
         y   = y + rand_step(scale_log);
         lst = (ends && i == n - 1) || $urandom_range(0, 40) == 0;
         queue_point(mk_point(1'b0, $urandom_range(0, 65535), $urandom_range(0, 65535),
                              x, y, rand_pv(), lst));
      end
   endtask

   // block idle: every queued point taken and every beat returned
   task automatic wait_drained();
      while (accepted_cnt != queued_cnt || rsp_beats != accepted_cnt) @(negedge clock);
   endtask

   task automatic write_decel(int value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[DEC_W-1:0];
      decel_cfg    = value[DEC_W-1:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // rising edge: timeout, predictor on accepted points, checker on result beats
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= LIMIT_CYC) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         req_took <= !reset && req_ch.valid && req_ch.ready;
         if (!reset) begin
            if (req_ch.valid && req_ch.ready) begin
               got_pt.first    = req_ch.first;
               got_pt.start_v  = req_ch.start_velocity;
               got_pt.target_v = req_ch.target_velocity;
               got_pt.pos_x    = req_ch.pos_x;
               got_pt.pos_y    = req_ch.pos_y;
               got_pt.pv       = req_ch.point_velocity;
               got_pt.last     = req_ch.last;
               capped_q.insert(capped_q.size(), decel_limit_step(got_pt));
               accepted_cnt++;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
               if (capped_q.size() == 0) begin
                  report_mismatch($sformatf("beat %0d with nothing expected, vel %0d",
                                            rsp_beats, rsp_ch.new_velocity));
               end else begin
                  want_res = capped_q.pop_front();
                  if (rsp_ch.new_velocity !== want_res.vel ||
                      rsp_ch.reached_target !== want_res.reached ||
                      rsp_ch.last_out !== want_res.last) begin
                     report_mismatch($sformatf(
                        "beat %0d vel %0d/%0d reached %0b/%0b last %0b/%0b",
                        rsp_beats, rsp_ch.new_velocity, want_res.vel,
                        rsp_ch.reached_target, want_res.reached,
                        rsp_ch.last_out, want_res.last));
                  end
               end
               rsp_beats++;
            end
         end
      end
   end

   // driver: bursts of beats with random gaps, holds a beat until taken
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_took) begin
         if (gap_left != 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (point_q.size() != 0) begin
            got_pt = point_q.pop_front();
            req_ch.first           <= got_pt.first;
            req_ch.start_velocity  <= got_pt.start_v;
            req_ch.target_velocity <= got_pt.target_v;
            req_ch.pos_x           <= got_pt.pos_x;
            req_ch.pos_y           <= got_pt.pos_y;
            req_ch.point_velocity  <= got_pt.pv;
            req_ch.last            <= got_pt.last;
            req_ch.valid           <= 1'b1;
            if (burst_left <= 1) begin
               // next burst; some with no gap at all, a few with a long one
               burst_left = $urandom_range(1, 24);
               case ($urandom_range(0, 7))
                  0, 1:    gap_left = 0;
                  2:       gap_left = $urandom_range(20, 80);
                  default: gap_left = $urandom_range(1, 12);
               endcase
            end else begin
               burst_left--;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver: segments of stall patterns, plus two long hold-offs mid-run
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (holds_done < 2 && rsp_beats >= next_hold_at) begin
         // long hold-off while the sender keeps offering, block backs up
         hold_left = HOLD_CYC - 1;
         holds_done++;
         next_hold_at = 600;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_mode = stall_mode_type'($urandom_range(0, 2));
            seg_left = $urandom_range(20, 200);
         end else begin
            seg_left--;
         end
         case (seg_mode)
            RDY_ALWAYS: rsp_ch.ready <= 1'b1;
            RDY_HALF:   rsp_ch.ready <= $urandom_range(0, 1) == 1;
            default:    rsp_ch.ready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   initial begin
      int decels[5];
      int phase_start;

      // every input known from time zero
      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      req_ch.valid           = 1'b0;
      req_ch.first           = 1'b0;
      req_ch.start_velocity  = '0;
      req_ch.target_velocity = '0;
      req_ch.pos_x           = '0;
      req_ch.pos_y           = '0;
      req_ch.point_velocity  = '0;
      req_ch.last            = 1'b0;
      rsp_ch.ready           = 1'b0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed points at the reset deceleration of 1000 mm/s^2
      @(posedge clock);
      // points before any start work on the zero reset state
      queue_point(mk_point(1'b0, 0, 0, 100, 0, 500, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, 100, 50, -65535, 1'b0));
      // full start velocity, one short step, then a saturated step down to zero
      queue_point(mk_point(1'b1, 65535, 0, 0, 0, 65535, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, 1000, 0, 65535, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, 1000 + (1 << 24), 0, 40000, 1'b0));
      // past the target: no second flag
      queue_point(mk_point(1'b0, 0, 0, 1005 + (1 << 24), 3, 200, 1'b0));
      // start below the floor is raised on the next point
      queue_point(mk_point(1'b1, 100, 5000, -7, 9, 6000, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, -6, 10, 6000, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, -5, 11, 4000, 1'b1));
      // start and final point in one beat
      queue_point(mk_point(1'b1, 300, 0, 0, 0, 9000, 1'b1));
      // negative point velocity on a start, then a final point passes unchanged
      queue_point(mk_point(1'b1, 2000, 100, 0, 0, -300, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, 0, 100, 1500, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, 0, 300, 65535, 1'b1));
      // position extremes, opposite corners, floor at the top
      queue_point(mk_point(1'b1, 65535, 65535, 32'h8000_0000, 32'h7fff_ffff, 65535, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1, 1'b0));
      // both axes just under the ceiling: saturates after the root
      queue_point(mk_point(1'b1, 50000, 0, 0, 0, 60000, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, 16777215, 16777215, 60000, 1'b0));
      // one axis at exactly 2^24 saturates directly
      queue_point(mk_point(1'b1, 40000, 10, 0, 0, 0, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, 16777216, 0, 0, 1'b0));
      // zero start, zero step
      queue_point(mk_point(1'b1, 0, 0, 5, 5, 0, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, 5, 5, 17, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, 5, 5, -1, 1'b1));
      // 3-4-5 step
      queue_point(mk_point(1'b1, 65535, 1, 0, 0, 65535, 1'b0));
      queue_point(mk_point(1'b0, 0, 0, 3, 4, 65535, 1'b0));
      wait_drained();

      // random phases, one deceleration setting each, extremes included
      decels[0] = 1;
      decels[1] = 65535;
      decels[2] = 1000;
      decels[3] = $urandom_range(1, 65535);
      decels[4] = 37;
      foreach (decels[i]) begin
         write_decel(decels[i]);
         @(posedge clock);
         phase_start = queued_cnt;
         while (queued_cnt - phase_start < PHASE_PTS) begin
            if ($urandom_range(0, 9) == 0) begin
               // stray point with arbitrary content
               queue_point(mk_point($urandom_range(0, 3) == 0, $urandom_range(0, 65535),
                                    $urandom_range(0, 65535), $urandom, $urandom,
                                    rand_pv(), $urandom_range(0, 3) == 0));
            end else begin
               add_profile();
            end
         end
         // sender pauses here until every beat is back
         wait_drained();
      end

      // let any stray beat surface before the verdict
      repeat (DRAIN_CYC) @(negedge clock);
      if (capped_q.size() != 0)
         report_mismatch($sformatf("%0d beats never returned", capped_q.size()));
      if (err_cnt == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/dlvp_pkg.sv
hdl/dlvp_req_if.sv
hdl/dlvp_rsp_if.sv
hdl/dlvp_root.sv
hdl/dlvp_core.sv
hdl/decel_limited_velocity_profile_unit.sv
dv/tb.sv
